/* hw/rtl/dsf_pkg.sv */
// Shared codes, frame type and helper function for the DLE packet framer
package dsf_pkg;

    // line control codes
    localparam logic [7:0] CODE_SOH  = 8'h01;
    localparam logic [7:0] CODE_EOT  = 8'h04;
    localparam logic [7:0] CODE_ACK  = 8'h06;
    localparam logic [7:0] CODE_DLE  = 8'h10;
    localparam logic [7:0] CODE_NACK = 8'h15;

    // packet number range
    localparam logic [7:0] PKT_FIRST = 8'd128;
    localparam logic [7:0] PKT_LAST  = 8'd255;

    // longest frame one payload byte can cause
    localparam int FRAME_MAX = 7;
    localparam int CNT_W     = $clog2(FRAME_MAX + 1);

    // expanded line bytes for one payload byte
    typedef struct packed {
        logic [FRAME_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
    } frame_t;

    // true for bytes that need a DLE in front
    function automatic logic is_control(input logic [7:0] b);
        return b inside {CODE_SOH, CODE_EOT, CODE_ACK, CODE_DLE, CODE_NACK};
    endfunction

endpackage

/* hw/rtl/dsf_expand.sv */
// Framing state and expansion of one payload byte into its line bytes
module dsf_expand
    import dsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output frame_t     frame
);

    logic       inside_reg;
    logic [7:0] parity_reg;
    logic [7:0] pkt_num_reg;
    logic [7:0] parity_next;
    logic [7:0] pkt_num_next;
    logic [7:0] trailer_parity;

    // payload parity and next packet number
    always_comb
    begin
        parity_next    = (inside_reg ? parity_reg : 8'h00) ^ data_byte;
        trailer_parity = parity_next ^ pkt_num_reg;
        pkt_num_next   = (pkt_num_reg == PKT_LAST) ? PKT_FIRST : pkt_num_reg + 8'd1;
    end

    // build the byte list for this beat
    always_comb
    begin
        logic [CNT_W-1:0] n;
        frame = '0;
        n     = '0;
        if (!inside_reg)
        begin
            frame.bytes[n] = CODE_SOH;
            n = n + 1'b1;
        end
        if (is_control(data_byte))
        begin
            frame.bytes[n] = CODE_DLE;
            n = n + 1'b1;
        end
        frame.bytes[n] = data_byte;
        n = n + 1'b1;
        if (last_byte)
        begin
            frame.bytes[n] = pkt_num_reg;
            n = n + 1'b1;
            if (is_control(trailer_parity))
            begin
                frame.bytes[n] = CODE_DLE;
                n = n + 1'b1;
            end
            frame.bytes[n] = trailer_parity;
            n = n + 1'b1;
            frame.bytes[n] = CODE_EOT;
            n = n + 1'b1;
        end
        frame.count = n;
    end

    // packet state update on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg  <= 1'b0;
            parity_reg  <= 8'h00;
            pkt_num_reg <= PKT_FIRST;
        end
        else if (take)
        begin
            if (last_byte)
            begin
                inside_reg  <= 1'b0;
                parity_reg  <= 8'h00;
                pkt_num_reg <= pkt_num_next;
            end
            else
            begin
                inside_reg <= 1'b1;
                parity_reg <= parity_next;
            end
        end
    end

endmodule

/* hw/rtl/dle_stuffed_packet_framer.sv */
// Top level of the DLE byte-stuffing packet framer with XOR parity
//
// Each accepted payload beat is expanded at once into its line bytes (SOH on
// the first byte of a packet, DLE escapes, and on the last byte the packet
// number, parity and EOT) and loaded into a seven-entry output shift register
// that sends one line byte per cycle while out_stall is low. A payload beat
// causes 1 to 7 line bytes (2 for a typical escaped or packet-opening byte,
// 1 for a plain one). The next payload beat is accepted in the same cycle
// the previous frame's final byte is taken, so the line side sees no gap.
// run_end marks the final line byte of each payload beat.
module dle_stuffed_packet_framer
    import dsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_end
);

    frame_t           frame;
    logic [7:0]       buf_reg [FRAME_MAX];
    logic [CNT_W-1:0] cnt_reg;
    logic             in_take;
    logic             out_take;
    logic             frame_done;

    dsf_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .frame     (frame)
    );

    // handshake
    assign out_valid  = (cnt_reg != '0);
    assign run_end    = (cnt_reg == CNT_W'(1));
    assign out_byte   = buf_reg[0];
    assign out_take   = out_valid && !out_stall;
    assign frame_done = out_take && run_end;
    assign in_stall   = out_valid && !frame_done;
    assign in_take    = in_valid && !in_stall;

    // remaining byte count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (in_take)
            cnt_reg <= frame.count;
        else if (out_take)
            cnt_reg <= cnt_reg - 1'b1;
    end

    // output shift register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            for (int i = 0; i < FRAME_MAX; i++)
                buf_reg[i] <= frame.bytes[i];
        end
        else if (out_take)
        begin
            for (int i = 0; i < FRAME_MAX - 1; i++)
                buf_reg[i] <= buf_reg[i+1];
        end
    end

endmodule

/* hw/rtl/dsf_checker.sv */
// Port-level checks for the DLE packet framer and the bind that attaches them
module dsf_checker
    import dsf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_end
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_end))
        else $error("output beat changed while stalled");

    // an accepted payload beat produces line bytes next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no line byte after accepted payload beat");

    // a frame keeps going until its run_end byte
    a_frame_cont: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !run_end |=> out_valid)
        else $error("frame ended without run_end");

    // input stalls only while a frame is pending
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no frame pending");

    // overlap only when the final byte leaves
    a_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && out_valid |-> run_end && !out_stall)
        else $error("payload beat accepted mid-frame");

endmodule

bind dle_stuffed_packet_framer dsf_checker u_dsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_end   (run_end)
);
